FILE: hdl/fqd_pkg.sv
// fqd_pkg: shared constants, types and the ring slot function of the
// dedup queue. no dependencies.
package fqd_pkg;

  localparam int unsigned DEPTH        = 16;
  localparam int unsigned IDX_W        = $clog2(DEPTH);
  localparam int unsigned CNT_W        = $clog2(DEPTH + 1);
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned ENTRY_CNT_W  = 5;

  typedef enum logic [1:0] {
    REQ_PUSH  = 2'd0,
    REQ_POP   = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_DEDUP = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    STS_DONE       = 2'd0,
    STS_PUSH_FULL  = 2'd1,
    STS_POP_EMPTY  = 2'd2,
    STS_RSVD       = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP_WAIT,
    ST_DD_GETI,
    ST_DD_CMP
  } state_e;

  typedef struct packed {
    logic    push;
    logic    pop;
    logic    pop_load;
    logic    clear;
    logic    dd_start;
    logic    dd_geti;
    logic    dd_next_j;
    logic    dd_keep;
    logic    dd_next_i;
    logic    dd_done;
    logic    set_status;
    status_e status;
  } cmd_t;

  typedef struct packed {
    logic count_zero;
    logic count_one;
    logic count_full;
    logic count_lt2;
    logic match;
    logic j_last;
    logic i_last;
  } sts_t;

  function automatic logic [IDX_W-1:0] slot(input logic [IDX_W-1:0] head,
                                            input logic [IDX_W-1:0] k);
    logic [IDX_W:0] sum;
    sum = {1'b0, head} + {1'b0, k};
    if (sum >= (IDX_W+1)'(DEPTH)) begin
      sum = sum - (IDX_W+1)'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

FILE: hdl/fifo_queue_with_dedup.sv
// fifo_queue_with_dedup: bounded ring queue with push, pop, clear and dedup.
// push, clear and refused requests complete from ST_IDLE; a pop that leaves
// entries passes through ST_POP_WAIT (ram read of the new head). dedup steps
// through ST_DD_GETI and ST_DD_CMP per entry. one request in flight; push and
// clear sustain 1 request per cycle while no result is stalled at the output.
// rst_ni async active low empties the queue; no clearing pass over the ram.
module fifo_queue_with_dedup (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [1:0]                        req_type_i,
  input  logic signed [fqd_pkg::DATA_W-1:0] push_value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [1:0]                        status_o,
  output logic signed [fqd_pkg::DATA_W-1:0] front_value_o,
  output logic signed [fqd_pkg::DATA_W-1:0] back_value_o,
  output logic [fqd_pkg::ENTRY_CNT_W-1:0]   entry_count_o,
  output logic                              is_empty_o
);

  fqd_pkg::cmd_t cmd;
  fqd_pkg::sts_t sts;

  fqd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .req_type_i  (req_type_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  fqd_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_value_i  (push_value_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .status_o      (status_o),
    .front_value_o (front_value_o),
    .back_value_o  (back_value_o),
    .entry_count_o (entry_count_o),
    .is_empty_o    (is_empty_o)
  );

endmodule

FILE: hdl/fqd_ram.sv
// fqd_ram: generic single write, single read ram with registered read data
// no dependencies
module fqd_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: hdl/fqd_ctrl.sv
// fqd_ctrl: request sequencer for push, pop, clear and duplicate removal
// depends on fqd_pkg
module fqd_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [1:0]    req_type_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  fqd_pkg::sts_t sts_i,
  output fqd_pkg::cmd_t cmd_o
);

  fqd_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;
  logic            accept;
  logic            emit;

  assign in_ready_o  = (state_q == fqd_pkg::ST_IDLE) && (!out_valid_q || out_ready_i);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fqd_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.status = fqd_pkg::STS_DONE;
    emit    = 1'b0;
    case (state_q)
      fqd_pkg::ST_IDLE: begin
        if (accept) begin
          cmd_o.set_status = 1'b1;
          case (fqd_pkg::req_e'(req_type_i))
            fqd_pkg::REQ_PUSH: begin
              emit = 1'b1;
              if (sts_i.count_full) begin
                cmd_o.status = fqd_pkg::STS_PUSH_FULL;
              end else begin
                cmd_o.push = 1'b1;
              end
            end
            fqd_pkg::REQ_POP: begin
              if (sts_i.count_zero) begin
                cmd_o.status = fqd_pkg::STS_POP_EMPTY;
                emit = 1'b1;
              end else begin
                cmd_o.pop = 1'b1;
                if (sts_i.count_one) begin
                  emit = 1'b1;
                end else begin
                  state_d = fqd_pkg::ST_POP_WAIT;
                end
              end
            end
            fqd_pkg::REQ_CLEAR: begin
              cmd_o.clear = 1'b1;
              emit = 1'b1;
            end
            fqd_pkg::REQ_DEDUP: begin
              if (sts_i.count_lt2) begin
                emit = 1'b1;
              end else begin
                cmd_o.dd_start = 1'b1;
                state_d = fqd_pkg::ST_DD_GETI;
              end
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end
      fqd_pkg::ST_POP_WAIT: begin
        cmd_o.pop_load = 1'b1;
        emit = 1'b1;
        state_d = fqd_pkg::ST_IDLE;
      end
      fqd_pkg::ST_DD_GETI: begin
        cmd_o.dd_geti = 1'b1;
        state_d = fqd_pkg::ST_DD_CMP;
      end
      fqd_pkg::ST_DD_CMP: begin
        if (!sts_i.match && !sts_i.j_last) begin
          cmd_o.dd_next_j = 1'b1;
        end else begin
          // value is new when the last kept entry did not match
          cmd_o.dd_keep = !sts_i.match;
          if (sts_i.i_last) begin
            cmd_o.dd_done = 1'b1;
            emit = 1'b1;
            state_d = fqd_pkg::ST_IDLE;
          end else begin
            cmd_o.dd_next_i = 1'b1;
            state_d = fqd_pkg::ST_DD_GETI;
          end
        end
      end
      default: begin
        state_d = fqd_pkg::ST_IDLE;
      end
    endcase
    out_valid_d = (out_valid_q && !out_ready_i) || emit;
  end

endmodule

FILE: hdl/fqd_datapath.sv
// fqd_datapath: ring storage, head and count, front and back registers and
// the compaction indexes. depends on fqd_pkg and fqd_ram
module fqd_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic signed [fqd_pkg::DATA_W-1:0] push_value_i,
  input  fqd_pkg::cmd_t                     cmd_i,
  output fqd_pkg::sts_t                     sts_o,
  output logic [1:0]                        status_o,
  output logic signed [fqd_pkg::DATA_W-1:0] front_value_o,
  output logic signed [fqd_pkg::DATA_W-1:0] back_value_o,
  output logic [fqd_pkg::ENTRY_CNT_W-1:0]   entry_count_o,
  output logic                              is_empty_o
);

  logic [fqd_pkg::IDX_W-1:0]  head_q, head_d;
  logic [fqd_pkg::CNT_W-1:0]  count_q, count_d;
  logic [fqd_pkg::DATA_W-1:0] front_q, front_d;
  logic [fqd_pkg::DATA_W-1:0] back_q, back_d;
  logic [fqd_pkg::DATA_W-1:0] v_q, v_d;
  logic [fqd_pkg::CNT_W-1:0]  i_q, i_d;
  logic [fqd_pkg::CNT_W-1:0]  n_q, n_d;
  logic [fqd_pkg::IDX_W-1:0]  j_q, j_d;
  fqd_pkg::status_e           status_q, status_d;

  logic [fqd_pkg::CNT_W-1:0]  i_inc;
  logic [fqd_pkg::CNT_W-1:0]  j_inc;
  logic                       we;
  logic [fqd_pkg::IDX_W-1:0]  waddr;
  logic [fqd_pkg::DATA_W-1:0] wdata;
  logic [fqd_pkg::IDX_W-1:0]  raddr;
  logic [fqd_pkg::DATA_W-1:0] rdata;

  fqd_ram #(
    .WIDTH (fqd_pkg::DATA_W),
    .DEPTH (fqd_pkg::DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign i_inc = i_q + fqd_pkg::CNT_W'(1);
  assign j_inc = fqd_pkg::CNT_W'(j_q) + fqd_pkg::CNT_W'(1);

  assign sts_o.count_zero = (count_q == '0);
  assign sts_o.count_one  = (count_q == fqd_pkg::CNT_W'(1));
  assign sts_o.count_full = (count_q == fqd_pkg::CNT_W'(fqd_pkg::DEPTH));
  assign sts_o.count_lt2  = (count_q < fqd_pkg::CNT_W'(2));
  assign sts_o.match      = (rdata == v_q);
  assign sts_o.j_last     = (j_inc == n_q);
  assign sts_o.i_last     = (i_inc == count_q);

  // ram ports
  always_comb begin
    we    = cmd_i.push || cmd_i.dd_keep;
    waddr = fqd_pkg::slot(head_q, n_q[fqd_pkg::IDX_W-1:0]);
    wdata = v_q;
    if (cmd_i.push) begin
      waddr = fqd_pkg::slot(head_q, count_q[fqd_pkg::IDX_W-1:0]);
      wdata = push_value_i;
    end
    raddr = head_q;
    if (cmd_i.pop || cmd_i.dd_start) begin
      raddr = fqd_pkg::slot(head_q, fqd_pkg::IDX_W'(1));
    end else if (cmd_i.dd_next_j) begin
      raddr = fqd_pkg::slot(head_q, j_inc[fqd_pkg::IDX_W-1:0]);
    end else if (cmd_i.dd_next_i) begin
      raddr = fqd_pkg::slot(head_q, i_inc[fqd_pkg::IDX_W-1:0]);
    end
  end

  always_comb begin
    head_d   = head_q;
    count_d  = count_q;
    front_d  = front_q;
    back_d   = back_q;
    v_d      = v_q;
    i_d      = i_q;
    n_d      = n_q;
    j_d      = j_q;
    status_d = status_q;
    if (cmd_i.set_status) begin
      status_d = cmd_i.status;
    end
    if (cmd_i.push) begin
      count_d = count_q + fqd_pkg::CNT_W'(1);
      back_d  = push_value_i;
      if (count_q == '0) begin
        front_d = push_value_i;
      end
    end
    if (cmd_i.pop) begin
      head_d  = fqd_pkg::slot(head_q, fqd_pkg::IDX_W'(1));
      count_d = count_q - fqd_pkg::CNT_W'(1);
    end
    if (cmd_i.pop_load) begin
      front_d = rdata;
    end
    if (cmd_i.clear) begin
      head_d  = '0;
      count_d = '0;
    end
    if (cmd_i.dd_start) begin
      i_d    = fqd_pkg::CNT_W'(1);
      n_d    = fqd_pkg::CNT_W'(1);
      back_d = front_q;
    end
    if (cmd_i.dd_geti) begin
      v_d = rdata;
      j_d = '0;
    end
    if (cmd_i.dd_next_j) begin
      j_d = j_inc[fqd_pkg::IDX_W-1:0];
    end
    if (cmd_i.dd_keep) begin
      n_d    = n_q + fqd_pkg::CNT_W'(1);
      back_d = v_q;
    end
    if (cmd_i.dd_next_i) begin
      i_d = i_inc;
    end
    if (cmd_i.dd_done) begin
      count_d = n_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= '0;
      count_q  <= '0;
      status_q <= fqd_pkg::STS_DONE;
    end else begin
      head_q   <= head_d;
      count_q  <= count_d;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    front_q <= front_d;
    back_q  <= back_d;
    v_q     <= v_d;
    i_q     <= i_d;
    n_q     <= n_d;
    j_q     <= j_d;
  end

  assign status_o      = status_q;
  assign is_empty_o    = (count_q == '0);
  assign front_value_o = is_empty_o ? '0 : front_q;
  assign back_value_o  = is_empty_o ? '0 : back_q;
  assign entry_count_o = fqd_pkg::ENTRY_CNT_W'(count_q);

endmodule

FILE: hdl/fqd_checker.sv
// fqd_checker: port level assertions for fifo_queue_with_dedup, bound to it
// depends on fqd_pkg
module fqd_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_o,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic [1:0]                        status_o,
  input logic signed [fqd_pkg::DATA_W-1:0] front_value_o,
  input logic signed [fqd_pkg::DATA_W-1:0] back_value_o,
  input logic [fqd_pkg::ENTRY_CNT_W-1:0]   entry_count_o,
  input logic                              is_empty_o
);

  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (is_empty_o == (entry_count_o == '0)))
    else $error("empty flag disagrees with count");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && is_empty_o) |-> (front_value_o == '0 && back_value_o == '0))
    else $error("empty queue shows nonzero values");

  a_refusal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == fqd_pkg::STS_POP_EMPTY) |-> is_empty_o)
    else $error("pop refused on nonempty queue");

  a_no_take_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |-> !in_ready_o)
    else $error("request taken while result stalled");

  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(entry_count_o)))
    else $error("stalled result changed");

endmodule

bind fifo_queue_with_dedup fqd_checker u_fqd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .status_o      (status_o),
  .front_value_o (front_value_o),
  .back_value_o  (back_value_o),
  .entry_count_o (entry_count_o),
  .is_empty_o    (is_empty_o)
);

FILE: bench/tb_fifo_queue_with_dedup.sv
// tb_fifo_queue_with_dedup: self-checking bench for the dedup ring queue, a
// directed table then weighted random requests, checked against a local
// queue predictor. depends on fqd_pkg and fifo_queue_with_dedup.
module tb_fifo_queue_with_dedup;

  typedef struct packed {
    fqd_pkg::status_e status;
    logic [31:0]      front;
    logic [31:0]      back;
    logic [4:0]       cnt;
    logic             is_empty;
  } result_t;

  typedef struct packed {
    fqd_pkg::req_e    req;
    logic [31:0]      value;
    logic [4:0]       reps;
    logic             typed;
    fqd_pkg::status_e e_status;
    logic [31:0]      e_front;
    logic [31:0]      e_back;
    logic [4:0]       e_cnt;
    logic             e_empty;
  } dir_row_t;

  typedef enum logic [1:0] {
    MIX_FILL,
    MIX_DRAIN,
    MIX_BOTH
  } mix_e;

  localparam int NUM_DIR  = 15;
  localparam int NUM_RAND = 950;

  localparam dir_row_t DIR_ROWS [NUM_DIR] = '{
    '{fqd_pkg::REQ_POP,   32'h0000_0000, 5'd1, 1'b1,
      fqd_pkg::STS_POP_EMPTY, 32'h0, 32'h0, 5'd0, 1'b1},
    '{fqd_pkg::REQ_DEDUP, 32'h0000_0000, 5'd1, 1'b1,
      fqd_pkg::STS_DONE, 32'h0, 32'h0, 5'd0, 1'b1},
    '{fqd_pkg::REQ_PUSH,  32'h7fff_ffff, 5'd1, 1'b1,
      fqd_pkg::STS_DONE, 32'h7fff_ffff, 32'h7fff_ffff, 5'd1, 1'b0},
    '{fqd_pkg::REQ_DEDUP, 32'hffff_ffff, 5'd1, 1'b1,
      fqd_pkg::STS_DONE, 32'h7fff_ffff, 32'h7fff_ffff, 5'd1, 1'b0},
    '{fqd_pkg::REQ_PUSH,  32'h8000_0000, 5'd1, 1'b1,
      fqd_pkg::STS_DONE, 32'h7fff_ffff, 32'h8000_0000, 5'd2, 1'b0},
    '{fqd_pkg::REQ_PUSH,  32'h7fff_ffff, 5'd1, 1'b0,
      fqd_pkg::STS_DONE, 32'h0, 32'h0, 5'd0, 1'b0},
    '{fqd_pkg::REQ_PUSH,  32'h8000_0000, 5'd1, 1'b0,
      fqd_pkg::STS_DONE, 32'h0, 32'h0, 5'd0, 1'b0},
    '{fqd_pkg::REQ_PUSH,  32'h0000_0000, 5'd1, 1'b0,
      fqd_pkg::STS_DONE, 32'h0, 32'h0, 5'd0, 1'b0},
    '{fqd_pkg::REQ_DEDUP, 32'h0000_0000, 5'd1, 1'b0,
      fqd_pkg::STS_DONE, 32'h0, 32'h0, 5'd0, 1'b0},
    '{fqd_pkg::REQ_POP,   32'h0000_0000, 5'd1, 1'b0,
      fqd_pkg::STS_DONE, 32'h0, 32'h0, 5'd0, 1'b0},
    '{fqd_pkg::REQ_PUSH,  32'h5a5a_a5a5, 5'd7, 1'b0,
      fqd_pkg::STS_DONE, 32'h0, 32'h0, 5'd0, 1'b0},
    '{fqd_pkg::REQ_PUSH,  32'hffff_ffff, 5'd7, 1'b0,
      fqd_pkg::STS_DONE, 32'h0, 32'h0, 5'd0, 1'b0},
    '{fqd_pkg::REQ_PUSH,  32'h1234_5678, 5'd1, 1'b0,
      fqd_pkg::STS_DONE, 32'h0, 32'h0, 5'd0, 1'b0},
    '{fqd_pkg::REQ_DEDUP, 32'h0000_0000, 5'd1, 1'b0,
      fqd_pkg::STS_DONE, 32'h0, 32'h0, 5'd0, 1'b0},
    '{fqd_pkg::REQ_CLEAR, 32'hdead_beef, 5'd1, 1'b1,
      fqd_pkg::STS_DONE, 32'h0, 32'h0, 5'd0, 1'b1}
  };

  localparam logic [31:0] EXTREMES [4] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff};

  logic                                clk_i        = 1'b0;
  logic                                rst_ni       = 1'b0;
  logic                                in_valid_i   = 1'b0;
  logic                                in_ready_o;
  logic [1:0]                          req_type_i   = fqd_pkg::REQ_PUSH;
  logic signed [fqd_pkg::DATA_W-1:0]   push_value_i = '0;
  logic                                out_valid_o;
  logic                                out_ready_i  = 1'b0;
  logic [1:0]                          status_o;
  logic signed [fqd_pkg::DATA_W-1:0]   front_value_o;
  logic signed [fqd_pkg::DATA_W-1:0]   back_value_o;
  logic [fqd_pkg::ENTRY_CNT_W-1:0]     entry_count_o;
  logic                                is_empty_o;

  logic        typed_on     = 1'b0;
  result_t     typed_result = '0;
  logic        no_gaps      = 1'b0;

  logic [31:0] ring [fqd_pkg::DEPTH];
  int unsigned ring_head  = 0;
  int unsigned ring_count = 0;

  result_t     pending_results [$];
  int unsigned err_count = 0;

  fifo_queue_with_dedup u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .req_type_i    (req_type_i),
    .push_value_i  (push_value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .front_value_o (front_value_o),
    .back_value_o  (back_value_o),
    .entry_count_o (entry_count_o),
    .is_empty_o    (is_empty_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic result_t predict_request(fqd_pkg::req_e req, logic [31:0] value);
    logic [31:0] kept [fqd_pkg::DEPTH];
    int unsigned n_kept;
    bit          seen;
    result_t     res;
    res        = '0;
    res.status = fqd_pkg::STS_DONE;
    n_kept     = 0;
    case (req)
      fqd_pkg::REQ_PUSH: begin
        if (ring_count >= fqd_pkg::DEPTH) begin
          res.status = fqd_pkg::STS_PUSH_FULL;
        end else begin
          ring[(ring_head + ring_count) % fqd_pkg::DEPTH] = value;
          ring_count++;
        end
      end
      fqd_pkg::REQ_POP: begin
        if (ring_count == 0) begin
          res.status = fqd_pkg::STS_POP_EMPTY;
        end else begin
          ring_head = (ring_head + 1) % fqd_pkg::DEPTH;
          ring_count--;
        end
      end
      fqd_pkg::REQ_CLEAR: begin
        ring_head  = 0;
        ring_count = 0;
      end
      default: begin
        if (ring_count >= 2) begin
          for (int unsigned i = 0; i < ring_count; i++) begin
            seen = 1'b0;
            for (int unsigned j = 0; j < n_kept; j++) begin
              if (kept[j] == ring[(ring_head + i) % fqd_pkg::DEPTH]) seen = 1'b1;
            end
            if (!seen) begin
              kept[n_kept] = ring[(ring_head + i) % fqd_pkg::DEPTH];
              n_kept++;
            end
          end
          for (int unsigned i = 0; i < n_kept; i++) begin
            ring[(ring_head + i) % fqd_pkg::DEPTH] = kept[i];
          end
          ring_count = n_kept;
        end
      end
    endcase
    if (ring_count != 0) begin
      res.front = ring[ring_head];
      res.back  = ring[(ring_head + ring_count - 1) % fqd_pkg::DEPTH];
    end
    res.cnt      = 5'(ring_count);
    res.is_empty = (ring_count == 0);
    return res;
  endfunction

  task automatic flag_error(string what, result_t exp_res, result_t got_res);
    err_count++;
    if (err_count <= 10) begin
      $display("%s: exp sts=%0d front=%h back=%h cnt=%0d empty=%0d",
               what, exp_res.status, exp_res.front, exp_res.back, exp_res.cnt,
               exp_res.is_empty);
      $display("%s: got sts=%0d front=%h back=%h cnt=%0d empty=%0d",
               what, got_res.status, got_res.front, got_res.back, got_res.cnt,
               got_res.is_empty);
    end
  endtask

  // expectations are queued before results are taken, in one process
  always @(posedge clk_i) begin
    result_t exp_res;
    result_t got_res;
    if (rst_ni && in_valid_i && in_ready_o) begin
      exp_res = predict_request(fqd_pkg::req_e'(req_type_i), push_value_i);
      if (typed_on) exp_res = typed_result;
      pending_results.push_back(exp_res);
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      got_res = '{fqd_pkg::status_e'(status_o), front_value_o, back_value_o, entry_count_o,
                  is_empty_o};
      if (pending_results.size() == 0) begin
        flag_error("unexpected result", '0, got_res);
      end else begin
        exp_res = pending_results.pop_front();
        if (got_res.status !== exp_res.status || got_res.front !== exp_res.front ||
            got_res.back !== exp_res.back || got_res.cnt !== exp_res.cnt ||
            got_res.is_empty !== exp_res.is_empty) begin
          flag_error("mismatch", exp_res, got_res);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    out_ready_i <= no_gaps || ($urandom_range(0, 99) >= 6);
  end

  task automatic send_request(fqd_pkg::req_e req, logic [31:0] value, logic typed,
                              result_t exp_res);
    while (!no_gaps && $urandom_range(0, 99) < 6) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    req_type_i   <= req;
    push_value_i <= value;
    typed_on     <= typed;
    typed_result <= exp_res;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  initial begin
    fqd_pkg::req_e req;
    logic [31:0]   value;
    mix_e          mix;
    int unsigned   pick;
    mix = MIX_BOTH;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < NUM_DIR; r++) begin
      for (int k = 0; k < DIR_ROWS[r].reps; k++) begin
        send_request(DIR_ROWS[r].req, DIR_ROWS[r].value, DIR_ROWS[r].typed,
                     '{DIR_ROWS[r].e_status, DIR_ROWS[r].e_front, DIR_ROWS[r].e_back,
                       DIR_ROWS[r].e_cnt, DIR_ROWS[r].e_empty});
      end
    end

    for (int n = 0; n < NUM_RAND; n++) begin
      if (n % 24 == 0) mix = mix_e'($urandom_range(0, 2));
      no_gaps <= (n >= 350 && n < 550);
      pick = $urandom_range(0, 99);
      case (mix)
        MIX_FILL: begin
          req = (pick < 78) ? fqd_pkg::REQ_PUSH : (pick < 90) ? fqd_pkg::REQ_POP :
                (pick < 97) ? fqd_pkg::REQ_DEDUP : fqd_pkg::REQ_CLEAR;
        end
        MIX_DRAIN: begin
          req = (pick < 20) ? fqd_pkg::REQ_PUSH : (pick < 90) ? fqd_pkg::REQ_POP :
                (pick < 97) ? fqd_pkg::REQ_DEDUP : fqd_pkg::REQ_CLEAR;
        end
        default: begin
          req = (pick < 48) ? fqd_pkg::REQ_PUSH : (pick < 88) ? fqd_pkg::REQ_POP :
                (pick < 96) ? fqd_pkg::REQ_DEDUP : fqd_pkg::REQ_CLEAR;
        end
      endcase
      // small values make duplicates common
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
        value = 32'($urandom_range(0, 5)) - 32'd2;
      end else if (pick < 9) begin
        value = $urandom();
      end else begin
        value = EXTREMES[$urandom_range(0, 3)];
      end
      send_request(req, value, 1'b0, '0);
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    err_count += pending_results.size();
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
